// File: hw/rtl/mtmp_pkg.sv
// ----------------------------------------------------------------------------
// mtmp_pkg
// Shared constants, types and controller commands for the modular
// matrix-transpose multiply block.
// ----------------------------------------------------------------------------
package mtmp_pkg;

  localparam int MAX_TERMS = 16;
  localparam int MAX_ROWS  = 16;

  localparam int TERM_W   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  // no more than 16 results per data row
  localparam int ROWS_LIM = (MAX_ROWS < 16) ? MAX_ROWS : 16;

  localparam int VAL_W  = 16;
  localparam int MOD_W  = 16;
  localparam int RIU_W  = 5;
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = 38;
  localparam int CNT_W  = $clog2(ACC_W + 1);

  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  // register indexes, decoded from paddr[2]
  localparam logic REG_MODULUS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  // input item kinds carried on tuser
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_DATA = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } mtmp_state_e;

  typedef struct packed {
    logic coef_wr;
    logic data_cap;
    logic mul;
    logic acc;
    logic row_clr;
    logic div_start;
    logic emit;
    logic acc_clr;
  } mtmp_cmd_t;

  typedef struct packed {
    logic row_end;
    logic div_done;
    logic out_busy;
    logic last_row;
  } mtmp_stat_t;

endpackage

// File: hw/rtl/mtmp_modred.sv
// ----------------------------------------------------------------------------
// mtmp_modred
// Bit-serial floor modulo of a signed accumulator by an unsigned modulus.
// One quotient bit per cycle over the accumulator magnitude.
// ----------------------------------------------------------------------------
module mtmp_modred (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [mtmp_pkg::ACC_W-1:0]        acc_i,
  input  logic [mtmp_pkg::MOD_W-1:0]        modulus_i,
  output logic                              done_o,
  output logic [mtmp_pkg::MOD_W-1:0]        residue_o
);
  import mtmp_pkg::*;

  logic             busy_q, done_q, neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [ACC_W-1:0] mag_q;
  logic [MOD_W-1:0] rem_q;
  logic [MOD_W:0]   rem_shift, rem_step;

  assign rem_shift = {rem_q, mag_q[ACC_W-1]};
  assign rem_step  = (rem_shift >= {1'b0, modulus_i}) ? rem_shift - {1'b0, modulus_i}
                                                      : rem_shift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(ACC_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= acc_i[ACC_W-1];
      mag_q <= acc_i[ACC_W-1] ? (~acc_i) + ACC_W'(1) : acc_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_step[MOD_W-1:0];
      mag_q <= {mag_q[ACC_W-2:0], 1'b0};
    end
  end

  // negative sums fold back into 0..m-1
  always_comb begin
    if (modulus_i == '0) begin
      residue_o = '0;
    end else if (neg_q && (rem_q != '0)) begin
      residue_o = modulus_i - rem_q;
    end else begin
      residue_o = rem_q;
    end
  end

  assign done_o = done_q;

endmodule

// File: hw/rtl/mtmp_datapath.sv
// ----------------------------------------------------------------------------
// mtmp_datapath
// Coefficient memory, per-row multiply lanes and accumulators, reduction
// unit and output register.
// ----------------------------------------------------------------------------
module mtmp_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mtmp_pkg::mtmp_cmd_t                 cmd_i,
  output mtmp_pkg::mtmp_stat_t                stat_o,
  input  logic [3:0]                          coef_row_i,
  input  logic [3:0]                          term_index_i,
  input  logic [mtmp_pkg::VAL_W-1:0]          value_i,
  input  logic                                row_end_i,
  input  logic [mtmp_pkg::MOD_W-1:0]          modulus_i,
  input  logic [mtmp_pkg::ROW_W-1:0]          row_last_i,
  output logic                                m_valid_o,
  input  logic                                m_ready_i,
  output logic [mtmp_pkg::MOD_W-1:0]          residue_o,
  output logic [3:0]                          out_column_o,
  output logic                                run_last_o
);
  import mtmp_pkg::*;

  // one word per term, one lane per coefficient row
  logic [MAX_ROWS-1:0][VAL_W-1:0] coef_mem_q [MAX_TERMS];
  logic [MAX_ROWS-1:0][VAL_W-1:0] coef_rd_q;

  logic signed [VAL_W-1:0]  val_q;
  logic                     term_ok_q, row_end_q;
  logic signed [PROD_W-1:0] prod_q [MAX_ROWS];
  logic [ACC_W-1:0]         acc_q  [MAX_ROWS];
  logic [ROW_W-1:0]         row_cnt_q;

  logic [TERM_W-1:0] term_sel;
  logic [ROW_W-1:0]  lane_sel;
  logic              load_ok, term_ok;
  logic              div_done;
  logic [MOD_W-1:0]  div_res;

  logic             m_valid_q, run_last_q;
  logic [MOD_W-1:0] residue_q;
  logic [3:0]       column_q;

  assign term_sel = TERM_W'(term_index_i);
  assign lane_sel = ROW_W'(coef_row_i);
  assign term_ok  = int'(term_index_i) < MAX_TERMS;
  assign load_ok  = term_ok && (int'(coef_row_i) < MAX_ROWS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.coef_wr && load_ok) begin
      coef_mem_q[term_sel][lane_sel] <= value_i;
    end
    if (cmd_i.data_cap) begin
      coef_rd_q <= coef_mem_q[term_sel];
      val_q     <= signed'(value_i);
      term_ok_q <= term_ok;
      row_end_q <= row_end_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      for (int r = 0; r < MAX_ROWS; r++) begin
        prod_q[r] <= val_q * signed'(coef_rd_q[r]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MAX_ROWS; r++) begin
        acc_q[r] <= '0;
      end
    end else if (cmd_i.acc_clr) begin
      for (int r = 0; r < MAX_ROWS; r++) begin
        acc_q[r] <= '0;
      end
    end else if (cmd_i.acc && term_ok_q) begin
      for (int r = 0; r < MAX_ROWS; r++) begin
        acc_q[r] <= acc_q[r] + {{(ACC_W-PROD_W){prod_q[r][PROD_W-1]}}, prod_q[r]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
    end else if (cmd_i.row_clr) begin
      row_cnt_q <= '0;
    end else if (cmd_i.emit) begin
      row_cnt_q <= row_cnt_q + ROW_W'(1);
    end
  end

  mtmp_modred u_modred (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .acc_i     (acc_q[row_cnt_q]),
    .modulus_i (modulus_i),
    .done_o    (div_done),
    .residue_o (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      residue_q  <= div_res;
      column_q   <= 4'(row_cnt_q);
      run_last_q <= stat_o.last_row;
    end
  end

  assign stat_o.row_end  = row_end_q;
  assign stat_o.div_done = div_done;
  assign stat_o.out_busy = m_valid_q && !m_ready_i;
  assign stat_o.last_row = (row_cnt_q == row_last_i);

  assign m_valid_o    = m_valid_q;
  assign residue_o    = residue_q;
  assign out_column_o = column_q;
  assign run_last_o   = run_last_q;

endmodule

// File: hw/rtl/mtmp_ctrl.sv
// ----------------------------------------------------------------------------
// mtmp_ctrl
// Sequencer: coefficient loads, element multiply-accumulate, and per-row
// reduction and emission at the end of a data row.
// ----------------------------------------------------------------------------
module mtmp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  action_i,
  output logic                  in_ready_o,
  input  mtmp_pkg::mtmp_stat_t  stat_i,
  output mtmp_pkg::mtmp_cmd_t   cmd_o
);
  import mtmp_pkg::*;

  mtmp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (action_i == ACT_LOAD) begin
            cmd_o.coef_wr = 1'b1;
          end else begin
            cmd_o.data_cap = 1'b1;
            state_d        = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        if (stat_i.row_end) begin
          cmd_o.row_clr = 1'b1;
          state_d       = ST_DIV_START;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (stat_i.div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          if (stat_i.last_row) begin
            cmd_o.acc_clr = 1'b1;
            state_d       = ST_IDLE;
          end else begin
            state_d = ST_DIV_START;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> !stat_i.out_busy)
    else $error("result loaded while output register still held");

  a_div_clears_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> !stat_i.div_done)
    else $error("reduction done flag not cleared on start");

  a_acc_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.acc |-> $past(cmd_o.mul))
    else $error("accumulate without preceding multiply");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.acc_clr |-> (cmd_o.emit && stat_i.last_row))
    else $error("accumulators cleared before final result");

endmodule

// File: hw/rtl/matrix_transpose_multiply_mod_p.sv
// ----------------------------------------------------------------------------
// matrix_transpose_multiply_mod_p
// Data rows times transposed coefficient matrix, reduced with floor modulo.
// ----------------------------------------------------------------------------
// Coefficient load: one beat per cycle while the sequencer is idle. Data element:
//   coefficient memory read, lane multiply, accumulate; no new beat is taken until done.
// Row end runs the bit-serial modulo unit (38 steps) once per coefficient row
//   in use, and each result waits out any output stall.
// Reset (async, active low) clears control, accumulators, modulus to 2 and
//   rows_in_use to 1; the coefficient memory is not cleared.
module matrix_transpose_multiply_mod_p (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // slave stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [mtmp_pkg::IN_TDATA_W-1:0]        s_axis_tdata,  // coef_row, term_index, value
  input  logic                                   s_axis_tuser,  // action
  input  logic                                   s_axis_tlast,  // row_end
  // master stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [mtmp_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,  // residue, out_column, zero pad
  output logic                                   m_axis_tlast,  // run_last
  // configuration
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [mtmp_pkg::ADDR_W-1:0]            paddr,
  input  logic [mtmp_pkg::DATA_W-1:0]            pwdata,
  output logic [mtmp_pkg::DATA_W-1:0]            prdata,
  output logic                                   pready
);
  import mtmp_pkg::*;

  logic [MOD_W-1:0] modulus_q;
  logic [RIU_W-1:0] rows_q, rows_eff;
  logic [ROW_W-1:0] row_last;
  logic             cfg_wr;

  mtmp_cmd_t        cmd;
  mtmp_stat_t       stat;
  logic [MOD_W-1:0] residue;
  logic [3:0]       out_column;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MOD_W'(2);
      rows_q    <= RIU_W'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MODULUS) begin
        modulus_q <= pwdata[MOD_W-1:0];
      end else begin
        rows_q <= pwdata[RIU_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_ROWS) ? DATA_W'(rows_q) : DATA_W'(modulus_q);

  always_comb begin
    if (rows_q == '0) begin
      rows_eff = RIU_W'(1);
    end else if (int'(rows_q) > ROWS_LIM) begin
      rows_eff = RIU_W'(ROWS_LIM);
    end else begin
      rows_eff = rows_q;
    end
  end

  assign row_last = ROW_W'(rows_eff - RIU_W'(1));

  mtmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .action_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mtmp_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .coef_row_i   (s_axis_tdata[3:0]),
    .term_index_i (s_axis_tdata[7:4]),
    .value_i      (s_axis_tdata[23:8]),
    .row_end_i    (s_axis_tlast),
    .modulus_i    (modulus_q),
    .row_last_i   (row_last),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .residue_o    (residue),
    .out_column_o (out_column),
    .run_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, out_column, residue};

endmodule

// File: test/matrix_transpose_multiply_mod_p_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_transpose_multiply_mod_p_checker
// Watches the slave, master and register ports of the block. Keeps its own
// coefficient table, row sums and register copies, works out the residues
// each data row end must produce, and compares each result beat, field by
// field, against the oldest expected residue. Register reads are checked too.
// ----------------------------------------------------------------------------
module matrix_transpose_multiply_mod_p_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [mtmp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // coef_row, term_index, value
  input  logic                             s_axis_tuser,   // action
  input  logic                             s_axis_tlast,   // row_end
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [mtmp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // residue, out_column, zero pad
  input  logic                             m_axis_tlast,   // run_last
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mtmp_pkg::ADDR_W-1:0]      paddr,
  input  logic [mtmp_pkg::DATA_W-1:0]      pwdata,
  input  logic [mtmp_pkg::DATA_W-1:0]      prdata,
  input  logic                             pready,
  output int                               mismatch_count,
  output int                               residues_pending
);
  import mtmp_pkg::*;

  typedef struct packed {
    logic [MOD_W-1:0] residue;
    logic [ROW_W-1:0] column;
    logic             last;
  } residue_beat_t;

  logic signed [VAL_W-1:0] coef_words [MAX_ROWS][MAX_TERMS];
  logic signed [ACC_W-1:0] row_sums [MAX_ROWS];
  logic [MOD_W-1:0]        modulus_q;
  logic [RIU_W-1:0]        rows_q;
  residue_beat_t           expected_q [$];
  int                      errors = 0;

  assign mismatch_count = errors;

  // floor modulo: result in 0..m-1 for nonzero m, also for negative sums; zero for m = 0
  function automatic logic [MOD_W-1:0] floor_residue(logic signed [ACC_W-1:0] sum,
                                                     logic [MOD_W-1:0] m);
    longint s;
    longint r;
    if (m == '0) return '0;
    s = sum;
    r = s % longint'(m);
    if (r < 0) r = r + longint'(m);
    return MOD_W'(r);
  endfunction

  task automatic report(string what, longint want, longint got);
    if (errors < 10) $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what,
                              want, got);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    residue_beat_t    want;
    int               n;
    logic [ROW_W-1:0] row;
    logic [TERM_W-1:0] term;
    logic signed [VAL_W-1:0] val;
    longint           prod;
    logic [DATA_W-1:0] cfg_read;
    if (!rst_ni) begin
      modulus_q = MOD_W'(2);
      rows_q    = RIU_W'(1);
      foreach (row_sums[r]) row_sums[r] = '0;
      expected_q.delete();
      residues_pending <= 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_MODULUS) modulus_q = pwdata[MOD_W-1:0];
          else rows_q = pwdata[RIU_W-1:0];
        end else begin
          cfg_read = (paddr[2] == REG_MODULUS) ? DATA_W'(modulus_q) : DATA_W'(rows_q);
          if (prdata !== cfg_read) report("register read", cfg_read, prdata);
        end
      end

      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result beat, residue", -1, m_axis_tdata[MOD_W-1:0]);
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tdata[MOD_W-1:0] !== want.residue)
            report("residue", want.residue, m_axis_tdata[MOD_W-1:0]);
          if (m_axis_tdata[MOD_W +: ROW_W] !== want.column)
            report("out_column", want.column, m_axis_tdata[MOD_W +: ROW_W]);
          if (m_axis_tlast !== want.last)
            report("run_last", want.last, m_axis_tlast);
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        row  = s_axis_tdata[ROW_W-1:0];
        term = s_axis_tdata[ROW_W +: TERM_W];
        val  = s_axis_tdata[ROW_W+TERM_W +: VAL_W];
        if (s_axis_tuser == ACT_LOAD) begin
          coef_words[row][term] = val;
        end else begin
          for (int r = 0; r < MAX_ROWS; r++) begin
            prod = longint'(val) * longint'(coef_words[r][term]);
            row_sums[r] = row_sums[r] + ACC_W'(prod);
          end
          if (s_axis_tlast) begin
            n = (rows_q == '0) ? 1 : ((rows_q > ROWS_LIM) ? ROWS_LIM : int'(rows_q));
            for (int r = 0; r < n; r++)
              expected_q.push_back('{residue: floor_residue(row_sums[r], modulus_q),
                                     column:  ROW_W'(r),
                                     last:    (r == n - 1)});
            foreach (row_sums[r]) row_sums[r] = '0;
          end
        end
      end

      residues_pending <= expected_q.size();
    end
  end

endmodule

// File: test/matrix_transpose_multiply_mod_p_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_transpose_multiply_mod_p_test
// Loads coefficient columns, then streams data rows of random length and
// content through the block under a series of modulus and row-count settings,
// with random source gaps and sink stalls. The checker does the prediction.
// ----------------------------------------------------------------------------
module matrix_transpose_multiply_mod_p_test;
  import mtmp_pkg::*;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // coef_row, term_index, value
  logic                   s_axis_tuser = 1'b0; // action
  logic                   s_axis_tlast = 1'b0; // row_end
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // residue, out_column, zero pad
  logic                   m_axis_tlast;        // run_last
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [ADDR_W-1:0]      paddr = '0;
  logic [DATA_W-1:0]      pwdata = '0;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;

  int mismatch_count;
  int residues_pending;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit written [MAX_ROWS][MAX_TERMS];

  matrix_transpose_multiply_mod_p dut (.*);

  matrix_transpose_multiply_mod_p_checker checker_inst (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  function automatic logic [VAL_W-1:0] rand_word();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0001;
      4:       return 16'h0000;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // a data element may only use a column whose every row has been loaded
  function automatic bit column_ready(int t);
    for (int r = 0; r < MAX_ROWS; r++)
      if (!written[r][t]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic send_beat(logic act, logic [ROW_W-1:0] row, logic [TERM_W-1:0] term,
                           logic [VAL_W-1:0] val, logic row_end);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {val, term, row};
    s_axis_tuser  <= act;
    s_axis_tlast  <= row_end;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic load_coef(int row, int term, logic [VAL_W-1:0] val, logic row_end);
    send_beat(ACT_LOAD, ROW_W'(row), TERM_W'(term), val, row_end);
    written[row][term] = 1'b1;
  endtask

  task automatic fill_column(int t);
    for (int r = 0; r < MAX_ROWS; r++)
      load_coef(r, t, rand_word(), 1'(($urandom_range(3) == 0)));
  endtask

  task automatic send_data_row(int len);
    int ready_cols[$];
    for (int t = 0; t < MAX_TERMS; t++)
      if (column_ready(t)) ready_cols.push_back(t);
    for (int i = 0; i < len; i++)
      send_beat(ACT_DATA, ROW_W'($urandom), TERM_W'(ready_cols[$urandom_range(ready_cols.size()-1)]),
                rand_word(), (i == len - 1));
  endtask

  task automatic apb_access(logic wr, logic idx, logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // drop valid, drain all residues, then cover a data beat still in flight
  task automatic await_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (residues_pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  initial begin
    int                ph;
    int                sent;
    int                pick;
    int                t;
    int                len;
    int                cols_added;
    logic [DATA_W-1:0] mod_val;
    logic [DATA_W-1:0] rows_val;

    cols_added = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: column 0 with edge coefficients, a load carrying row_end,
    // then short rows under the reset settings
    for (int r = 0; r < MAX_ROWS; r++) begin
      case (r)
        0:       load_coef(r, 0, 16'h8000, 1'b0);
        1:       load_coef(r, 0, 16'h7FFF, 1'b0);
        2:       load_coef(r, 0, 16'hFFFF, 1'b0);
        3:       load_coef(r, 0, 16'h0001, 1'b0);
        4:       load_coef(r, 0, 16'h0000, 1'b0);
        7:       load_coef(r, 0, rand_word(), 1'b1);
        default: load_coef(r, 0, rand_word(), 1'b0);
      endcase
    end
    send_beat(ACT_DATA, 4'hF, 4'h0, 16'h8000, 1'b1);
    send_beat(ACT_DATA, 4'h0, 4'h0, 16'h7FFF, 1'b0);
    send_beat(ACT_DATA, 4'hA, 4'h0, 16'hFFFF, 1'b1);
    for (int i = 0; i < 4; i++) send_beat(ACT_DATA, 4'h5, 4'h0, 16'h8000, (i == 3));

    for (ph = 0; ph < 8; ph++) begin
      await_idle();
      case (ph)
        0:       begin mod_val = 65535; rows_val = 16; end
        1:       begin mod_val = 0;     rows_val = 0;  end
        2:       begin mod_val = 1;     rows_val = 31; end
        3:       begin mod_val = 7;     rows_val = 5;  end
        4:       begin mod_val = $urandom_range(65535, 2); rows_val = 16; end
        5:       begin mod_val = 65521; rows_val = 17; end
        6:       begin mod_val = $urandom_range(65535, 2); rows_val = $urandom_range(16, 1); end
        default: begin mod_val = 2;     rows_val = 16; end
      endcase
      apb_access(1'b1, REG_MODULUS, mod_val);
      apb_access(1'b1, REG_ROWS, rows_val);
      apb_access(1'b0, REG_MODULUS, '0);
      apb_access(1'b0, REG_ROWS, '0);

      case (ph % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 64; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 64; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase

      if (ph == 0) fill_column(MAX_TERMS - 1);
      sent = 0;
      while (sent < 11) begin
        pick = $urandom_range(99);
        if (pick < 6 && cols_added < 2) begin
          do t = $urandom_range(MAX_TERMS - 2, 1); while (column_ready(t));
          fill_column(t);
          cols_added++;
        end else if (pick < 20) begin
          load_coef($urandom_range(MAX_ROWS - 1), $urandom_range(MAX_TERMS - 1), rand_word(),
                    1'($urandom_range(1)));
          sent++;
        end else begin
          // mostly short rows, now and then a longer one of 10 to 20 elements
          len = ($urandom_range(9) == 0) ? $urandom_range(20, 10) : $urandom_range(6, 1);
          send_data_row(len);
          sent += len;
        end
      end
    end

    await_idle();
    if (mismatch_count == 0 && residues_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/mtmp_pkg.sv
hw/rtl/mtmp_modred.sv
hw/rtl/mtmp_datapath.sv
hw/rtl/mtmp_ctrl.sv
hw/rtl/matrix_transpose_multiply_mod_p.sv
test/matrix_transpose_multiply_mod_p_checker.sv
test/matrix_transpose_multiply_mod_p_test.sv
